// ===== design/tpcb_pkg.sv =====
// Shared constants, word types and arithmetic helpers for the colour bleed block.
package tpcb_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Ring of two lines plus the window span, indexed by raster position
  localparam int RING_DEPTH = 2 * MAX_WIDTH + 2;
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int GAP_W  = $clog2(MAX_WIDTH + 3);

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEED  = 2'd2;

  // Input word operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Channel arithmetic
  localparam int CHAN_W = 8;
  localparam int SUM_W  = 10;  // four neighbours of 8 bits
  localparam int CNT_W  = 3;   // 0..4 neighbours
  localparam int RECIP_W = 11;
  localparam logic [RECIP_W-1:0] RECIP3 = 11'd683;  // 2^11 / 3, exact for sums up to 1020

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              last_of_frame;
  } out_word_t;

  // Line store entry
  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  localparam int PIX_W = $bits(pixel_t);

  // Window taps, read one per cycle
  typedef enum logic [2:0] {
    TAP_CENTRE = 3'd0,
    TAP_LEFT   = 3'd1,
    TAP_RIGHT  = 3'd2,
    TAP_UP     = 3'd3,
    TAP_DOWN   = 3'd4
  } tap_t;

  // Sequencer to averaging datapath
  typedef struct packed {
    logic clear;   // start of a new pixel
    logic take;    // read data valid this cycle
    logic centre;  // read data is the pixel itself
    logic use_nb;  // neighbour lies inside the image and has been received
  } avg_ctrl_t;

  // Truncated sum / count for a count of 1..4; 0 for no neighbour
  function automatic logic [CHAN_W-1:0] div_count(logic [SUM_W-1:0] sum,
                                                  logic [CNT_W-1:0] cnt);
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [CHAN_W-1:0]        q;
    prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP3);
    unique case (cnt)
      3'd1:    q = sum[CHAN_W-1:0];
      3'd2:    q = sum[CHAN_W:1];
      3'd3:    q = prod[RECIP_W+CHAN_W-1:RECIP_W];
      3'd4:    q = sum[CHAN_W+1:2];
      default: q = '0;
    endcase
    return q;
  endfunction

endpackage

// ===== design/transparent_pixel_color_bleed.sv =====
// Top level of the four-neighbour alpha bleed block over a raster pixel stream.
//
//  channel   direction  handshake            word
//  in        input      in_valid/in_ready    in_word_t: drain flag + RGBA pixel
//  out       output     out_valid/out_ready  out_word_t: RGBA pixel + last_of_frame
//  cfg       input      cfg_we               cfg_index selects width/height/enable
//
// Steps: a word that gives no result leaves the sequencer idle. A word that
// releases a pixel is accepted, then five line store reads (centre, left, right,
// up, down) go through the store's single read port, the last read data is awaited,
// and the output register is loaded; a stalled output register holds this final step.
// Reset: synchronous; counters and sequencer clear at once, no clearing pass. Line
// store contents stay undefined; only slots written in the current frame are used.
// The output register decouples the sides: the next word is accepted while a
// finished pixel still waits for out_ready.
module transparent_pixel_color_bleed (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tpcb_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tpcb_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [tpcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpcb_pkg::CFG_W-1:0]     cfg_data
);
  import tpcb_pkg::*;

  // line store ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pixel_t            mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [PIX_W-1:0]  mem_rdata;

  // sequencer to datapath
  avg_ctrl_t         avg_ctl;
  logic              bleed_en;
  pixel_t            result;

  // Raster counters, ring pointers, config and the read sequencer
  tpcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .avg_ctl   (avg_ctl),
    .bleed_en  (bleed_en),
    .result    (result)
  );

  // Ring of two lines plus two pixels; write and read never coincide since the
  // sequencer only writes while idle and only reads while stepping the window
  tpcb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sums neighbours with nonzero alpha, divides by the count (shifts, or a reciprocal for three)
  tpcb_avg u_avg (
    .clk      (clk),
    .ctl      (avg_ctl),
    .rd_pixel (pixel_t'(mem_rdata)),
    .bleed_en (bleed_en),
    .result   (result)
  );

endmodule

// ===== design/tpcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tpcb_avg.sv =====
// Neighbour accumulation and averaging datapath.
module tpcb_avg (
  input  logic                clk,
  input  tpcb_pkg::avg_ctrl_t ctl,
  input  tpcb_pkg::pixel_t    rd_pixel,
  input  logic                bleed_en,
  output tpcb_pkg::pixel_t    result
);
  import tpcb_pkg::*;

  pixel_t           centre;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      cnt   <= '0;
    end else if (ctl.take) begin
      if (ctl.centre) begin
        centre <= rd_pixel;
      end else if (ctl.use_nb && rd_pixel.alpha != '0) begin
        sum_r <= sum_r + SUM_W'(rd_pixel.red);
        sum_g <= sum_g + SUM_W'(rd_pixel.green);
        sum_b <= sum_b + SUM_W'(rd_pixel.blue);
        cnt   <= cnt + CNT_W'(1);
      end
    end
  end

  // With bleed enabled, transparent pixels take the neighbour average; alpha always passes
  always_comb begin
    result = centre;
    if (bleed_en && centre.alpha == '0) begin
      result.red   = div_count(sum_r, cnt);
      result.green = div_count(sum_g, cnt);
      result.blue  = div_count(sum_b, cnt);
    end
  end

endmodule

// ===== design/tpcb_ctrl.sv =====
// Configuration registers, raster counters, line store addressing and sequencer.
module tpcb_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  tpcb_pkg::in_word_t                    in_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output tpcb_pkg::out_word_t                   out_word,
  input  logic                                  cfg_we,
  input  logic [tpcb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tpcb_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  mem_we,
  output logic [tpcb_pkg::ADDR_W-1:0]           mem_waddr,
  output tpcb_pkg::pixel_t                      mem_wdata,
  output logic [tpcb_pkg::ADDR_W-1:0]           mem_raddr,
  output tpcb_pkg::avg_ctrl_t                   avg_ctl,
  output logic                                  bleed_en,
  input  tpcb_pkg::pixel_t                      result
);
  import tpcb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam int EXT_W = CFG_W + WDIM_W;
  localparam int HEXT_W = CFG_W + ROW_W;
  localparam logic [WDIM_W-1:0] W_RESET = WDIM_W'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
  localparam logic [ROW_W-1:0]  H_RESET = ROW_W'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
  localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(RING_DEPTH - 1);

  function automatic logic [WDIM_W-1:0] clamp_w(logic [CFG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    if (v == '0) return WDIM_W'(1);
    if (ext > EXT_W'(MAX_WIDTH)) return WDIM_W'(MAX_WIDTH);
    return WDIM_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] clamp_h(logic [CFG_W-1:0] v);
    logic [HEXT_W-1:0] ext;
    ext = HEXT_W'(v);
    if (v == '0) return ROW_W'(1);
    if (ext > HEXT_W'(MAX_HEIGHT)) return ROW_W'(MAX_HEIGHT);
    return ROW_W'(v);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_inc(logic [ADDR_W-1:0] a);
    return (a == RING_LAST) ? '0 : a + ADDR_W'(1);
  endfunction

  state_t            state;
  state_t            state_next;
  logic [WDIM_W-1:0] width_eff;
  logic [ROW_W-1:0]  height_eff;
  logic [COL_W-1:0]  in_col;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [GAP_W-1:0]  gap;       // pixels received but not yet sent
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] out_addr;
  tap_t              tap;
  tap_t              tap_q;
  logic              pend;

  logic              accept;
  logic              is_pixel;
  logic              full;
  logic              geo_write;
  logic [WDIM_W-1:0] col_inc;
  logic              col_wrap;
  logic [GAP_W-1:0]  gap_inc;
  logic              lag_full;
  logic              last_col;
  logic              last_row;
  logic              last_pix;
  logic              out_free;
  logic [ADDR_W:0]   up_diff;
  logic [ADDR_W:0]   dn_sum;
  logic [ADDR_W-1:0] up_addr;
  logic [ADDR_W-1:0] dn_addr;
  logic [ADDR_W-1:0] left_addr;
  logic              nb_use;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_pixel  = (in_word.operation == OP_PIXEL);
  assign full      = (in_row == height_eff);
  assign geo_write = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  assign col_inc  = WDIM_W'(in_col) + WDIM_W'(1);
  assign col_wrap = (col_inc == width_eff);
  assign gap_inc  = gap + GAP_W'(1);
  assign lag_full = (gap_inc >= GAP_W'(width_eff) + GAP_W'(2));

  assign last_col = (out_col == COL_W'(width_eff - WDIM_W'(1)));
  assign last_row = (out_row == height_eff - ROW_W'(1));
  assign last_pix = last_col && last_row;
  assign out_free = !out_valid || out_ready;

  // Line store write: the incoming pixel at its ring slot
  assign mem_we    = accept && is_pixel && !full;
  assign mem_waddr = wr_addr;
  assign mem_wdata = '{alpha: in_word.alpha, blue: in_word.blue,
                       green: in_word.green, red: in_word.red};

  // Ring addresses of the window around the outgoing pixel
  assign up_diff   = (ADDR_W+1)'(out_addr) - (ADDR_W+1)'(width_eff);
  assign up_addr   = up_diff[ADDR_W] ? ADDR_W'(up_diff + (ADDR_W+1)'(RING_DEPTH))
                                     : up_diff[ADDR_W-1:0];
  assign dn_sum    = (ADDR_W+1)'(out_addr) + (ADDR_W+1)'(width_eff);
  assign dn_addr   = (dn_sum >= (ADDR_W+1)'(RING_DEPTH))
                     ? ADDR_W'(dn_sum - (ADDR_W+1)'(RING_DEPTH)) : dn_sum[ADDR_W-1:0];
  assign left_addr = (out_addr == '0) ? RING_LAST : out_addr - ADDR_W'(1);

  always_comb begin
    unique case (tap)
      TAP_CENTRE: mem_raddr = out_addr;
      TAP_LEFT:   mem_raddr = left_addr;
      TAP_RIGHT:  mem_raddr = ring_inc(out_addr);
      TAP_UP:     mem_raddr = up_addr;
      TAP_DOWN:   mem_raddr = dn_addr;
      default:    mem_raddr = out_addr;
    endcase
  end

  // Neighbour inside the image and already received
  always_comb begin
    unique case (tap_q)
      TAP_LEFT:  nb_use = (out_col != '0);
      TAP_RIGHT: nb_use = !last_col && (gap > GAP_W'(1));
      TAP_UP:    nb_use = (out_row != '0);
      TAP_DOWN:  nb_use = !last_row && (gap > GAP_W'(width_eff));
      default:   nb_use = 1'b0;
    endcase
  end

  assign avg_ctl = '{clear:  (state == S_IDLE),
                     take:   pend,
                     centre: (tap_q == TAP_CENTRE),
                     use_nb: nb_use};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_pixel) begin
            if (!full && lag_full) state_next = S_READ;
          end else if (gap != '0) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        if (tap == TAP_DOWN) state_next = S_WAIT;
      end
      S_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      width_eff  <= W_RESET;
      height_eff <= H_RESET;
      bleed_en   <= 1'b1;
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      gap        <= '0;
      wr_addr    <= '0;
      out_addr   <= '0;
      tap        <= TAP_CENTRE;
      tap_q      <= TAP_CENTRE;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == S_READ);
      tap_q <= tap;

      if (state == S_READ) begin
        unique case (tap)
          TAP_CENTRE: tap <= TAP_LEFT;
          TAP_LEFT:   tap <= TAP_RIGHT;
          TAP_RIGHT:  tap <= TAP_UP;
          TAP_UP:     tap <= TAP_DOWN;
          default:    tap <= TAP_CENTRE;
        endcase
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        out_word  <= '{out_red: result.red, out_green: result.green,
                       out_blue: result.blue, out_alpha: result.alpha,
                       last_of_frame: last_pix};
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        priority case (cfg_index)
          REG_WIDTH:  width_eff  <= clamp_w(cfg_data);
          REG_HEIGHT: height_eff <= clamp_h(cfg_data);
          REG_BLEED:  bleed_en   <= cfg_data[0];
          default:    ;
        endcase
      end

      // Geometry change restarts the frame, pending pixels dropped
      if (geo_write) begin
        in_col   <= '0;
        in_row   <= '0;
        out_col  <= '0;
        out_row  <= '0;
        gap      <= '0;
        wr_addr  <= '0;
        out_addr <= '0;
      end else if (state == S_DONE && out_free) begin
        if (last_pix) begin
          // frame complete: start over
          in_col   <= '0;
          in_row   <= '0;
          out_col  <= '0;
          out_row  <= '0;
          gap      <= '0;
          wr_addr  <= '0;
          out_addr <= '0;
        end else begin
          gap      <= gap - GAP_W'(1);
          out_addr <= ring_inc(out_addr);
          if (last_col) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
      end else if (mem_we) begin
        wr_addr <= ring_inc(wr_addr);
        gap     <= gap_inc;
        if (col_wrap) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= COL_W'(col_inc);
        end
      end
    end
  end

endmodule

// ===== design/tpcb_checker.sv =====
// Port-level checks on the colour bleed block, bound to the top level.
module tpcb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tpcb_pkg::out_word_t out_word
);

  // A waiting word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // Reading the window steps through the sequencer states: no word straight after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("output word appeared one cycle after an accept");

  // A new word is only produced while input is held off
  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("output word produced while input was open");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind transparent_pixel_color_bleed tpcb_checker u_tpcb_checker (.*);

// ===== tb/bleed_checker.sv =====
// Channel monitor with a line-store predictor that checks every finished pixel word.
module bleed_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  tpcb_pkg::in_word_t             in_word,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  tpcb_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [tpcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpcb_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             pending_count,
  output int                             pixels_out,
  output int                             frame_ends
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpcb_pkg::*;

  pixel_t           ring [RING_DEPTH];
  int unsigned      in_col, in_line, out_pos;
  logic [CFG_W-1:0] width_reg, height_reg;
  logic             bleed_on;
  out_word_t        pending_pixels [$];
  int               n_bad, n_out, n_last;

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
    int unsigned ext;
    ext = 32'(v);
    if (ext == 0) return 1;
    if (ext > hi) return hi;
    return ext;
  endfunction

  // Finished colour of the oldest pixel still held; got = pixels received so far
  task automatic release_pixel(int unsigned wd, int unsigned ht, int unsigned got);
    pixel_t      px, nb;
    out_word_t   res;
    int unsigned col, line, cnt, sr, sg, sb;
    int unsigned nbr [4];
    bit          ok [4];
    px = ring[out_pos % RING_DEPTH];
    res.out_red       = px.red;
    res.out_green     = px.green;
    res.out_blue      = px.blue;
    res.out_alpha     = px.alpha;
    res.last_of_frame = (out_pos + 1 == wd * ht);
    if (bleed_on && px.alpha == 0) begin
      col  = out_pos % wd;
      line = out_pos / wd;
      nbr[0] = out_pos - 1;  ok[0] = (col != 0);
      nbr[1] = out_pos + 1;  ok[1] = (col != wd - 1);
      nbr[2] = out_pos - wd; ok[2] = (line != 0);
      nbr[3] = out_pos + wd; ok[3] = (line != ht - 1);
      cnt = 0; sr = 0; sg = 0; sb = 0;
      // a neighbour not yet received counts as outside
      for (int i = 0; i < 4; i++) begin
        if (ok[i] && nbr[i] < got) begin
          nb = ring[nbr[i] % RING_DEPTH];
          if (nb.alpha != 0) begin
            sr += 32'(nb.red); sg += 32'(nb.green); sb += 32'(nb.blue);
            cnt++;
          end
        end
      end
      res.out_red   = (cnt != 0) ? 8'(sr / cnt) : 8'd0;
      res.out_green = (cnt != 0) ? 8'(sg / cnt) : 8'd0;
      res.out_blue  = (cnt != 0) ? 8'(sb / cnt) : 8'd0;
    end
    pending_pixels.push_back(res);
    if (res.last_of_frame) begin
      out_pos = 0; in_col = 0; in_line = 0;
    end else begin
      out_pos++;
    end
  endtask

  task automatic take_word(in_word_t w);
    int unsigned wd, ht, got;
    wd  = clamp_dim(width_reg, MAX_WIDTH);
    ht  = clamp_dim(height_reg, MAX_HEIGHT);
    got = in_line * wd + in_col;
    if (w.operation == OP_PIXEL) begin
      // pixels beyond a complete frame are dropped
      if (got < wd * ht) begin
        ring[got % RING_DEPTH] = {w.alpha, w.blue, w.green, w.red};
        in_col++;
        if (in_col >= wd) begin
          in_col = 0;
          in_line++;
        end
        got++;
        if (got - out_pos >= wd + 2) release_pixel(wd, ht, got);
      end
    end else if (out_pos < got) begin
      release_pixel(wd, ht, got);
    end
  endtask

  task automatic check_word(out_word_t seen);
    out_word_t want;
    if (pending_pixels.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%t: pixel word with none expected: r=%0d g=%0d b=%0d a=%0d last=%0d",
                 $time, seen.out_red, seen.out_green, seen.out_blue, seen.out_alpha,
                 seen.last_of_frame);
    end else begin
      want = pending_pixels.pop_front();
      n_out++;
      if (want.last_of_frame) n_last++;
      if (seen !== want) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"%t: pixel %0d mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0d,",
                    " got r=%0d g=%0d b=%0d a=%0d last=%0d"}, $time, n_out - 1,
                   want.out_red, want.out_green, want.out_blue, want.out_alpha,
                   want.last_of_frame, seen.out_red, seen.out_green, seen.out_blue,
                   seen.out_alpha, seen.last_of_frame);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_col = 0; in_line = 0; out_pos = 0;
      width_reg  = CFG_W'(MAX_WIDTH);
      height_reg = CFG_W'(MAX_HEIGHT);
      bleed_on   = 1'b1;
      pending_pixels.delete();
      n_bad = 0; n_out = 0; n_last = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH: begin
            width_reg = cfg_data;
            in_col = 0; in_line = 0; out_pos = 0;
          end
          REG_HEIGHT: begin
            height_reg = cfg_data;
            in_col = 0; in_line = 0; out_pos = 0;
          end
          REG_BLEED: bleed_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_word(in_word);
      if (out_valid && out_ready) check_word(out_word);
    end
    mismatch_count <= n_bad;
    pending_count  <= pending_pixels.size();
    pixels_out     <= n_out;
    frame_ends     <= n_last;
  end

endmodule

// ===== tb/transparent_pixel_color_bleed_test.sv =====
// Stimulus and verdict for the colour bleed block; checking sits in bleed_checker.
module transparent_pixel_color_bleed_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpcb_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH;
  logic [CFG_W-1:0]     cfg_data = '0;

  int          mismatches, outstanding, pixels_out, frame_ends;
  bit          calm = 1'b0;       // no idling on either side while set
  int unsigned words_sent = 0;    // every accepted word
  int unsigned counted = 0;       // words of the random part that do real work
  int unsigned settings = 0;      // geometry settings applied
  int unsigned frame_w, frame_h;  // saturated geometry, used to shape frames

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  transparent_pixel_color_bleed dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bleed_checker bleed_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending_count  (outstanding),
    .pixels_out     (pixels_out),
    .frame_ends     (frame_ends)
  );

  // Receiver stalls about a third of the cycles, never while calm
  always @(posedge clk)
    out_ready <= calm || ($urandom_range(0, 99) >= 33);

  // Offer one word, with a random idle gap in front; returns at the accepting edge
  // with valid still high, so a back-to-back word needs no second assignment.
  task automatic send(in_word_t w, bit counts);
    calm <= (counted >= 40 && counted < 140);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 33);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (counts) counted++;
  endtask

  // Hold the sender until every expected pixel is out, then give the sequencer
  // time to finish any word that produced nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // One register write, with cfg_we dropped again before returning, so cfg_we never toggles twice in a step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A geometry write restarts the frame and drops whatever is still held
  task automatic set_geometry(int unsigned wv, int unsigned hv);
    settle();
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    frame_w = (wv == 0) ? 1 : (wv > MAX_WIDTH) ? MAX_WIDTH : wv;
    frame_h = (hv == 0) ? 1 : (hv > MAX_HEIGHT) ? MAX_HEIGHT : hv;
    settings++;
  endtask

  function automatic in_word_t pix(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a);
    return {OP_PIXEL, r, g, b, a};
  endfunction

  // Random RGBA; transparent often so bleeding has work, channels pinned to
  // 0 or 255 now and then
  function automatic in_word_t any_pixel();
    in_word_t w;
    w = {OP_PIXEL, 32'($urandom)};
    if ($urandom_range(0, 7) == 0) w.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) w.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 7) == 0) w.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w.alpha = 8'h00;
      4:          w.alpha = 8'hFF;
      default:    ;
    endcase
    return w;
  endfunction

  // Drain tick; colour bits are junk and must be ignored
  function automatic in_word_t drain_word();
    return {OP_DRAIN, 32'($urandom)};
  endfunction

  initial begin
    int unsigned wv, hv, kind, total, n_px;
    bit          en;
    bit          wide_done;
    wide_done = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed ----
    // drain straight out of reset: nothing held, no word out
    send(drain_word(), 1'b0);

    // 3x3 frame: transparent corners (two neighbours each) and a transparent
    // centre with four nonzero-alpha neighbours whose red sums to 1020. Bottom-left
    // pixel is all zero. Transparent pixels carry colour that must be replaced.
    set_geometry(3, 3);
    write_reg(REG_BLEED, 1);
    send(pix(8'hAA, 8'h55, 8'h01, 8'h00), 1'b0);
    send(pix(8'hFF, 8'h00, 8'hFF, 8'hFF), 1'b0);
    send(pix(8'h80, 8'h7F, 8'hFF, 8'h00), 1'b0);
    send(pix(8'hFF, 8'hFF, 8'h00, 8'hFF), 1'b0);
    send(pix(8'h12, 8'h34, 8'h56, 8'h00), 1'b0);
    send(pix(8'hFF, 8'hFF, 8'hFF, 8'h01), 1'b0);
    send(pix(8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
    send(pix(8'hFF, 8'h00, 8'hFF, 8'h80), 1'b0);
    send(pix(8'hFF, 8'hFF, 8'hFF, 8'h00), 1'b0);
    // frame is complete, so this pixel is dropped
    send(any_pixel(), 1'b0);
    // last line plus one pixel still held: four drains, the last ends the frame
    repeat (4) send(drain_word(), 1'b0);
    // and one more with nothing left
    send(drain_word(), 1'b0);

    // ---- random frames ----
    while (counted < 320) begin
      if (!wide_done && counted >= 200) begin
        // both dimensions saturate to the maximum; fill past the first line
        // so a few pixels leave with down neighbours from the store,
        // drain a few early, then the next geometry write drops the rest
        set_geometry(2047, 2047);
        write_reg(REG_BLEED, 1);
        repeat (MAX_WIDTH + 6) send(any_pixel(), 1'b0);
        repeat (3) send(drain_word(), 1'b0);
        wide_done = 1'b1;
      end

      case ($urandom_range(0, 9))
        0:       wv = 0;   // saturates to one
        1:       wv = 1;
        default: wv = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 19))
        0:       hv = 0;
        1:       hv = 1;
        2:       hv = $urandom_range(0, 1) ? MAX_HEIGHT : 2047;  // tall, never finished
        default: hv = $urandom_range(2, 8);
      endcase
      en   = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);

      set_geometry(wv, hv);
      write_reg(REG_BLEED, 32'(en));
      total = frame_w * frame_h;

      if (kind < 15 || total > 200) begin
        // partial frame, abandoned by the next geometry write
        n_px = (total < 80) ? total : 80;
        n_px = $urandom_range(1, n_px);
        repeat (n_px) begin
          if ($urandom_range(0, 9) == 0) send(drain_word(), 1'b1);
          send(any_pixel(), 1'b1);
        end
      end else begin
        // drain at frame start: nothing held yet
        if ($urandom_range(0, 5) == 0) send(drain_word(), 1'b0);
        for (int i = 0; i < total; i++) begin
          // enable flipped mid-frame; takes effect on the pixels still held
          if (kind >= 85 && i == total / 2) begin
            settle();
            write_reg(REG_BLEED, en ? 0 : 1);
          end
          // early drain: the pixel leaves before its lower neighbour arrives
          if ($urandom_range(0, 19) == 0) send(drain_word(), 1'b1);
          send(any_pixel(), 1'b1);
        end
        if ($urandom_range(0, 4) == 0) send(any_pixel(), 1'b0);
        repeat (frame_w + 1) send(drain_word(), 1'b1);
        if ($urandom_range(0, 4) == 0) send(drain_word(), 1'b0);
      end
    end

    // ---- wind down ----
    settle();
    $display("Sent %0d words over %0d geometries: raster frames, early drains, dropped",
             words_sent, settings);
    $display("pixels, mid-frame restarts and enable flips; %0d pixels out, %0d frame ends.",
             pixels_out, frame_ends);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_500_000;
    $display("Timed out with %0d pixels still expected", outstanding);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
